// File: hdl/yrgb_pkg.sv
// Shared types, constants and the floor-and-clamp function of the YUYV to RGB converter.
`default_nettype none

package yrgb_pkg;

   // Fixed-point coefficients, scaled by 2^14.
   localparam int FRAC_BITS = 14;
   localparam logic signed [15:0] COEF_RV = 16'sd23044;
   localparam logic signed [15:0] COEF_GU = 16'sd5661;
   localparam logic signed [15:0] COEF_GV = 16'sd11746;
   localparam logic signed [15:0] COEF_BU = 16'sd19317;
   localparam logic [8:0] CHROMA_OFFSET = 9'd128;

   // Product of a 16-bit coefficient and a 9-bit signed chroma sample.
   localparam int PROD_W = 25;
   // Luma scaled by 2^14 plus up to two products.
   localparam int SUM_W = 26;
   localparam int QUOT_W = SUM_W - FRAC_BITS;

   // Configuration register indexes and port widths.
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_FRAME_DIVISOR = 1'b0;

   // Registered chroma products shared by both pixel lanes.
   typedef struct packed {
      logic signed [PROD_W-1:0] rv;
      logic signed [PROD_W-1:0] gu;
      logic signed [PROD_W-1:0] gv;
      logic signed [PROD_W-1:0] bu;
   } chroma_term_type;

   // One RGB888 pixel.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // Floor division by 2^14, then clamp to 0..255.
   function automatic logic [7:0] floor_clamp(input logic signed [SUM_W-1:0] sum);
      logic signed [QUOT_W-1:0] quot;
      logic [7:0] result;
      quot = sum[SUM_W-1:FRAC_BITS];
      if (quot < 0) begin
         result = 8'd0;
      end else if (quot > $signed(QUOT_W'(255))) begin
         result = 8'd255;
      end else begin
         result = quot[7:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: hdl/yrgb_chroma.sv
// Chroma stage: removes the offset from U and V and registers the four coefficient products.
`default_nettype none

module yrgb_chroma (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [7:0]                chroma_blue,
   input  wire logic [7:0]                chroma_red,
   output yrgb_pkg::chroma_term_type      terms_ff
);
   import yrgb_pkg::*;

   logic signed [8:0] u_s;
   logic signed [8:0] v_s;
   chroma_term_type   terms_in;

   // Centered chroma samples fit in nine signed bits.
   assign u_s = $signed({1'b0, chroma_blue} - CHROMA_OFFSET);
   assign v_s = $signed({1'b0, chroma_red} - CHROMA_OFFSET);

   // One constant multiply per term, both operands widened to the product width.
   always_comb begin
      terms_in.rv = PROD_W'(COEF_RV) * PROD_W'(v_s);
      terms_in.gu = PROD_W'(COEF_GU) * PROD_W'(u_s);
      terms_in.gv = PROD_W'(COEF_GV) * PROD_W'(v_s);
      terms_in.bu = PROD_W'(COEF_BU) * PROD_W'(u_s);
   end

   // Products advance with the pipeline.
   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/yrgb_lane.sv
// Pixel lane: adds scaled luma to the shared chroma products, floors and clamps each color.
`default_nettype none

module yrgb_lane (
   input  wire logic [7:0]                luma,
   input  wire yrgb_pkg::chroma_term_type terms,
   output yrgb_pkg::pixel_type            pixel
);
   import yrgb_pkg::*;

   logic signed [SUM_W-1:0] luma_scaled;
   logic signed [SUM_W-1:0] red_sum;
   logic signed [SUM_W-1:0] green_sum;
   logic signed [SUM_W-1:0] blue_sum;

   // Luma times 2^14, never negative.
   assign luma_scaled = $signed({{(SUM_W-FRAC_BITS-8){1'b0}}, luma, {FRAC_BITS{1'b0}}});

   // Exact sums of the conversion equations.
   always_comb begin
      red_sum   = luma_scaled + SUM_W'(terms.rv);
      green_sum = luma_scaled - SUM_W'(terms.gu) - SUM_W'(terms.gv);
      blue_sum  = luma_scaled + SUM_W'(terms.bu);
   end

   // Floor and clamp into eight bits per color.
   always_comb begin
      pixel.red   = floor_clamp(red_sum);
      pixel.green = floor_clamp(green_sum);
      pixel.blue  = floor_clamp(blue_sum);
   end

endmodule

`default_nettype wire

// File: hdl/yuyv_to_rgb_frame_decimator.sv
// Top level: frame decimation control, chroma stage, two pixel lanes and the output register.
// The block takes one YUYV word per clock while rsp_tready is high and returns one word of two
// RGB888 pixels for every input word of a kept frame, registered first in the chroma multiplier
// stage and then in the output register fed by the lane adders and clamps. A word with frame_start
// set decides for its whole frame: the frame is kept when the phase counter is zero and
// sink_ready is set, and the phase then advances, wrapping at frame_divisor (0 acts as 1).
// Words of dropped frames are accepted like any other word and give no output. Throughput is
// one word per cycle as long as rsp_tready is high; req_tready falls only when both pipeline
// stages hold words that the sink has not taken.
`default_nettype none

module yuyv_to_rgb_frame_decimator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input stream
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
   input  wire logic [31:0]                         req_tdata,
   // frame_start[0], sink_ready[1]
   input  wire logic [1:0]                          req_tuser,
   // Result stream
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // red_first[7:0], green_first[15:8], blue_first[23:16],
   // red_second[31:24], green_second[39:32], blue_second[47:40]
   output      logic [47:0]                         rsp_tdata,
   // first_of_frame[0]
   output      logic [0:0]                          rsp_tuser,
   // Configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [yrgb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output      logic [31:0]                         csr_prdata,
   output      logic                                csr_pready
);
   import yrgb_pkg::*;

   logic [7:0]       frame_divisor_ff;
   logic [7:0]       frame_divisor_in;
   logic [7:0]       frame_phase_ff;
   logic [7:0]       frame_phase_in;
   logic             keep_frame_ff;
   logic             keep_frame_in;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [7:0]       s1_luma_first_ff;
   logic [7:0]       s1_luma_second_ff;
   logic             s1_first_ff;

   logic             out_valid_ff;
   logic             out_valid_in;
   pixel_type        out_first_ff;
   pixel_type        out_second_ff;
   logic             out_first_of_frame_ff;

   logic             accept;
   logic             frame_start;
   logic             sink_ready;
   logic             keep_now;
   logic             out_free;
   logic             s1_free;
   logic             csr_write;
   logic [7:0]       divisor_eff;
   logic [8:0]       phase_next;
   chroma_term_type  terms;
   pixel_type        pixel_first;
   pixel_type        pixel_second;

   // Configuration port, always ready.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frame_divisor_in = frame_divisor_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_FRAME_DIVISOR)) begin
         frame_divisor_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_IDX_FRAME_DIVISOR) begin
         csr_prdata = {24'd0, frame_divisor_ff};
      end
   end

   // Pipeline flow control: each stage moves when the one after it can take a word.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;

   assign frame_start = req_tuser[0];
   assign sink_ready  = req_tuser[1];

   // Frame decimation: the frame-start word samples the keep decision.
   assign divisor_eff = (frame_divisor_ff == 8'd0) ? 8'd1 : frame_divisor_ff;
   assign phase_next  = {1'b0, frame_phase_ff} + 9'd1;

   always_comb begin
      frame_phase_in = frame_phase_ff;
      keep_frame_in  = keep_frame_ff;
      if (accept && frame_start) begin
         keep_frame_in  = (frame_phase_ff == 8'd0) && sink_ready;
         frame_phase_in = (phase_next >= {1'b0, divisor_eff}) ? 8'd0 : phase_next[7:0];
      end
   end

   assign keep_now    = frame_start ? keep_frame_in : keep_frame_ff;
   assign s1_valid_in = s1_free ? (accept && keep_now) : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_divisor_ff <= 8'd1;
         frame_phase_ff   <= 8'd0;
         keep_frame_ff    <= 1'b0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         frame_divisor_ff <= frame_divisor_in;
         frame_phase_ff   <= frame_phase_in;
         keep_frame_ff    <= keep_frame_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // Stage one: luma and frame flag travel beside the chroma products.
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_luma_first_ff  <= req_tdata[7:0];
         s1_luma_second_ff <= req_tdata[23:16];
         s1_first_ff       <= frame_start;
      end
   end

   yrgb_chroma u_chroma (
      .clock       (clock),
      .load        (s1_free),
      .chroma_blue (req_tdata[15:8]),
      .chroma_red  (req_tdata[31:24]),
      .terms_ff    (terms)
   );

   // Two pixel lanes share the chroma products.
   yrgb_lane u_lane_first (
      .luma  (s1_luma_first_ff),
      .terms (terms),
      .pixel (pixel_first)
   );

   yrgb_lane u_lane_second (
      .luma  (s1_luma_second_ff),
      .terms (terms),
      .pixel (pixel_second)
   );

   // Output register merges both lanes into one result word.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_first_ff          <= pixel_first;
         out_second_ff         <= pixel_second;
         out_first_of_frame_ff <= s1_first_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_second_ff.blue, out_second_ff.green, out_second_ff.red,
                        out_first_ff.blue, out_first_ff.green, out_first_ff.red};
   assign rsp_tuser  = out_first_of_frame_ff;

endmodule

`default_nettype wire
